>>> src/kmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared constants and types of the minimum spanning tree unit.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int VERTEX_BITS = 6;
    localparam int NV_BITS     = 7;
    localparam int COST_BITS   = 22;
    localparam int RANK_BITS   = 3;
    localparam int NV_RESET    = 64;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef struct packed {
        logic                   clear;
        logic                   start;
        logic [VERTEX_BITS-1:0] vertex_a;
        logic [VERTEX_BITS-1:0] vertex_b;
    } uf_req_t;

    typedef struct packed {
        logic done;
        logic joined;
    } uf_rsp_t;

endpackage

>>> src/kmst_union_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_union_find
// Disjoint-set store with union by rank and find with path compression.
// ----------------------------------------------------------------------------
module kmst_union_find #(
    parameter int MAX_VERTICES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kmst_pkg::uf_req_t req,
    output kmst_pkg::uf_rsp_t rsp
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int RANK_W = kmst_pkg::RANK_BITS;
    localparam int WORD_W = IDX_W + RANK_W;

    typedef enum logic [2:0] {
        U_IDLE,
        U_FIND,
        U_COMP,
        U_UNITE,
        U_BUMP
    } state_t;

    logic [WORD_W-1:0] mem [MAX_VERTICES];
    logic [WORD_W-1:0] q_reg;
    logic [MAX_VERTICES-1:0] valid_reg, valid_next;

    state_t state_reg, state_next;
    logic side_reg, side_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] orig_reg, orig_next;
    logic [IDX_W-1:0] vb_reg, vb_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0] root_a_reg, root_a_next;
    logic [RANK_W-1:0] rank_a_reg, rank_a_next;
    logic [RANK_W-1:0] rank_b_reg, rank_b_next;
    logic done_reg, done_next;
    logic joined_reg, joined_next;

    logic we;
    logic [IDX_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] ent_parent;
    logic [RANK_W-1:0] ent_rank;

    assign ent_parent = valid_reg[cur_reg] ? q_reg[WORD_W-1:RANK_W] : cur_reg;
    assign ent_rank   = valid_reg[cur_reg] ? q_reg[RANK_W-1:0] : RANK_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        side_next   = side_reg;
        cur_next    = cur_reg;
        orig_next   = orig_reg;
        vb_next     = vb_reg;
        root_next   = root_reg;
        root_a_next = root_a_reg;
        rank_a_next = rank_a_reg;
        rank_b_next = rank_b_reg;
        done_next   = 1'b0;
        joined_next = joined_reg;
        valid_next  = valid_reg;
        we          = 1'b0;
        waddr       = cur_reg;
        wdata       = '0;
        raddr       = cur_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.clear)
                begin
                    valid_next = '0;
                end
                else if (req.start)
                begin
                    raddr      = req.vertex_a[IDX_W-1:0];
                    cur_next   = req.vertex_a[IDX_W-1:0];
                    orig_next  = req.vertex_a[IDX_W-1:0];
                    vb_next    = req.vertex_b[IDX_W-1:0];
                    side_next  = 1'b0;
                    state_next = U_FIND;
                end
            end
            U_FIND:
            begin
                if (ent_parent == cur_reg)
                begin
                    root_next = cur_reg;
                    if (side_reg)
                    begin
                        rank_b_next = ent_rank;
                    end
                    else
                    begin
                        rank_a_next = ent_rank;
                    end
                    raddr      = orig_reg;
                    cur_next   = orig_reg;
                    state_next = U_COMP;
                end
                else
                begin
                    raddr    = ent_parent;
                    cur_next = ent_parent;
                end
            end
            U_COMP:
            begin
                if (ent_parent == root_reg)
                begin
                    if (side_reg)
                    begin
                        state_next = U_UNITE;
                    end
                    else
                    begin
                        root_a_next = root_reg;
                        side_next   = 1'b1;
                        raddr       = vb_reg;
                        cur_next    = vb_reg;
                        orig_next   = vb_reg;
                        state_next  = U_FIND;
                    end
                end
                else
                begin
                    we                  = 1'b1;
                    waddr               = cur_reg;
                    wdata               = {root_reg, ent_rank};
                    valid_next[cur_reg] = 1'b1;
                    raddr               = ent_parent;
                    cur_next            = ent_parent;
                end
            end
            U_UNITE:
            begin
                done_next   = 1'b1;
                joined_next = 1'b1;
                state_next  = U_IDLE;
                if (root_a_reg == root_reg)
                begin
                    joined_next = 1'b0;
                end
                else if (rank_a_reg < rank_b_reg)
                begin
                    we                     = 1'b1;
                    waddr                  = root_a_reg;
                    wdata                  = {root_reg, rank_a_reg};
                    valid_next[root_a_reg] = 1'b1;
                end
                else
                begin
                    we                   = 1'b1;
                    waddr                = root_reg;
                    wdata                = {root_a_reg, rank_b_reg};
                    valid_next[root_reg] = 1'b1;
                    if (rank_a_reg == rank_b_reg)
                    begin
                        done_next  = 1'b0;
                        state_next = U_BUMP;
                    end
                end
            end
            U_BUMP:
            begin
                we                     = 1'b1;
                waddr                  = root_a_reg;
                wdata                  = {root_a_reg, rank_a_reg + RANK_W'(1)};
                valid_next[root_a_reg] = 1'b1;
                done_next              = 1'b1;
                joined_next            = 1'b1;
                state_next             = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
            joined_reg <= 1'b0;
            side_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            joined_reg <= joined_next;
            side_reg   <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        orig_reg   <= orig_next;
        vb_reg     <= vb_next;
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.joined = joined_reg;

endmodule

>>> src/kruskal_minimum_spanning_tree_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_unit
// Loads weighted edges, sorts them in place and emits the spanning tree edges.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_*      in   one edge per beat; tlast marks the final edge of the list
// m_*      out  tree edges, then a total record with tuser and tlast high
// cfg_*    in   vertex count register
//
// Loading takes one edge per cycle. After the final edge the edge memory is
// sorted by insertion. The walk runs one union-find query per edge, with an
// extra rank step when two ranks tie and an emit step for each tree edge.
// Reset sets the vertex count to 64 and empties the list. A stalled output
// holds the walk; no new edge is taken until the total record has been moved
// into the output register.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // vertex_a, vertex_b, weight
    input  logic [((12+WEIGHT_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // edge_a, edge_b, edge_weight, total_cost, overflow
    output logic [((35+WEIGHT_BITS+7)/8)*8-1:0]   m_tdata,
    // kind
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [kmst_pkg::NV_BITS-1:0]          cfg_wdata
);

    localparam int VB     = kmst_pkg::VERTEX_BITS;
    localparam int CB     = kmst_pkg::COST_BITS;
    localparam int NB     = kmst_pkg::NV_BITS;
    localparam int EW     = 2*VB + WEIGHT_BITS;
    localparam int OUT_W  = ((35+WEIGHT_BITS+7)/8)*8;
    localparam int CNT_W  = $clog2(MAX_EDGES+1);
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int OFS_C  = 2*VB + WEIGHT_BITS;
    localparam int OFS_O  = OFS_C + CB;

    typedef enum logic [3:0] {
        T_LOAD,
        T_SRT_NEXT,
        T_SRT_KEY,
        T_SRT_CMP,
        T_SRT_PUT,
        T_WALK_NEXT,
        T_WALK_RD,
        T_WALK_UF,
        T_EMIT,
        T_TOTAL
    } state_t;

    logic [EW-1:0] emem [MAX_EDGES];
    logic [EW-1:0] e_q;
    logic e_we;
    logic [EA_W-1:0] e_waddr;
    logic [EA_W-1:0] e_raddr;
    logic [EW-1:0] e_wdata;

    state_t state_reg, state_next;
    logic [NB-1:0] nv_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic drop_reg, drop_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [EW-1:0] key_reg, key_next;
    logic [EW-1:0] edge_reg, edge_next;
    logic [CB-1:0] cost_reg, cost_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic m_tuser_reg, m_tuser_next;
    logic m_tlast_reg, m_tlast_next;

    kmst_pkg::uf_req_t uf_req;
    kmst_pkg::uf_rsp_t uf_rsp;

    logic [NB-1:0] nv_eff;
    logic [VB-1:0] in_a;
    logic [VB-1:0] in_b;
    logic [WEIGHT_BITS-1:0] in_w;
    logic in_range;
    logic out_free;
    logic key_less;
    logic [CNT_W-1:0] i_dec;
    logic [CNT_W-1:0] j_dec;
    logic [CNT_W-1:0] j_dec2;

    assign nv_eff   = (nv_reg > NB'(MAX_VERTICES)) ? NB'(MAX_VERTICES) : nv_reg;
    assign in_a     = s_tdata[0 +: VB];
    assign in_b     = s_tdata[VB +: VB];
    assign in_w     = s_tdata[2*VB +: WEIGHT_BITS];
    assign in_range = ({1'b0, in_a} < nv_eff) && ({1'b0, in_b} < nv_eff);
    assign out_free = !m_tvalid_reg || m_tready;
    assign key_less = {~key_reg[EW-1], key_reg[EW-2:2*VB], key_reg[VB-1:0],
                       key_reg[2*VB-1:VB]}
                    < {~e_q[EW-1], e_q[EW-2:2*VB], e_q[VB-1:0], e_q[2*VB-1:VB]};
    assign i_dec    = i_reg - CNT_W'(1);
    assign j_dec    = j_reg - CNT_W'(1);
    assign j_dec2   = j_reg - CNT_W'(2);
    assign s_tready = (state_reg == T_LOAD);

    kmst_union_find #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_union_find (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (uf_req),
        .rsp  (uf_rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        drop_next     = drop_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        key_next      = key_reg;
        edge_next     = edge_reg;
        cost_next     = cost_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        e_we          = 1'b0;
        e_waddr       = count_reg[EA_W-1:0];
        e_wdata       = {in_w, in_b, in_a};
        e_raddr       = i_reg[EA_W-1:0];
        uf_req        = '0;
        uf_req.vertex_a = e_q[0 +: VB];
        uf_req.vertex_b = e_q[VB +: VB];
        case (state_reg)
            T_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (in_range)
                    begin
                        if (count_reg == CNT_W'(MAX_EDGES))
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            e_we       = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    if (s_tlast)
                    begin
                        i_next     = CNT_W'(1);
                        state_next = T_SRT_NEXT;
                    end
                end
            end
            T_SRT_NEXT:
            begin
                if (i_reg >= count_reg)
                begin
                    uf_req.clear = 1'b1;
                    i_next       = '0;
                    state_next   = T_WALK_NEXT;
                end
                else
                begin
                    state_next = T_SRT_KEY;
                end
            end
            T_SRT_KEY:
            begin
                key_next   = e_q;
                j_next     = i_reg;
                e_raddr    = i_dec[EA_W-1:0];
                state_next = T_SRT_CMP;
            end
            T_SRT_CMP:
            begin
                e_we    = 1'b1;
                e_waddr = j_reg[EA_W-1:0];
                if (key_less)
                begin
                    e_wdata = e_q;
                    j_next  = j_dec;
                    if (j_dec != '0)
                    begin
                        e_raddr = j_dec2[EA_W-1:0];
                    end
                    else
                    begin
                        state_next = T_SRT_PUT;
                    end
                end
                else
                begin
                    e_wdata    = key_reg;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = T_SRT_NEXT;
                end
            end
            T_SRT_PUT:
            begin
                e_we       = 1'b1;
                e_waddr    = j_reg[EA_W-1:0];
                e_wdata    = key_reg;
                i_next     = i_reg + CNT_W'(1);
                state_next = T_SRT_NEXT;
            end
            T_WALK_NEXT:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = T_TOTAL;
                end
                else
                begin
                    state_next = T_WALK_RD;
                end
            end
            T_WALK_RD:
            begin
                edge_next    = e_q;
                uf_req.start = 1'b1;
                state_next   = T_WALK_UF;
            end
            T_WALK_UF:
            begin
                if (uf_rsp.done)
                begin
                    if (uf_rsp.joined)
                    begin
                        cost_next  = cost_reg + CB'($signed(edge_reg[EW-1:2*VB]));
                        state_next = T_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = T_WALK_NEXT;
                    end
                end
            end
            T_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next                   = 1'b1;
                    m_tdata_next                    = '0;
                    m_tdata_next[0 +: EW]           = edge_reg;
                    m_tdata_next[OFS_C +: CB]       = cost_reg;
                    m_tdata_next[OFS_O]             = drop_reg;
                    m_tuser_next                    = kmst_pkg::KIND_EDGE;
                    m_tlast_next                    = 1'b0;
                    i_next                          = i_reg + CNT_W'(1);
                    state_next                      = T_WALK_NEXT;
                end
            end
            T_TOTAL:
            begin
                if (out_free)
                begin
                    m_tvalid_next             = 1'b1;
                    m_tdata_next              = '0;
                    m_tdata_next[OFS_C +: CB] = cost_reg;
                    m_tdata_next[OFS_O]       = drop_reg;
                    m_tuser_next              = kmst_pkg::KIND_TOTAL;
                    m_tlast_next              = 1'b1;
                    count_next                = '0;
                    cost_next                 = '0;
                    drop_next                 = 1'b0;
                    state_next                = T_LOAD;
                end
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            emem[e_waddr] <= e_wdata;
        end
        e_q <= emem[e_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_LOAD;
            nv_reg       <= NB'(kmst_pkg::NV_RESET);
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            cost_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            drop_reg     <= drop_next;
            cost_reg     <= cost_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                nv_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        key_reg     <= key_next;
        edge_reg    <= edge_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> test/kruskal_minimum_spanning_tree_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_unit_tb
// Streams edge lists into the spanning tree unit and checks every tree edge and
// total record against an in-bench union-find predictor, with random gaps and
// stalls on both streams and vertex count changes between lists.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree_unit_tb;

    localparam int MAX_V = 64;
    localparam int MAX_E = 1024;

    typedef struct {
        logic                             kind;
        logic [kmst_pkg::VERTEX_BITS-1:0] a;
        logic [kmst_pkg::VERTEX_BITS-1:0] b;
        logic [15:0]                      w;
        logic [kmst_pkg::COST_BITS-1:0]   cost;
        logic                             ovf;
        logic                             last;
    } tree_beat_t;

    class mst_scoreboard;
        tree_beat_t                       tree_q[$];
        logic [kmst_pkg::VERTEX_BITS-1:0] list_a[$];
        logic [kmst_pkg::VERTEX_BITS-1:0] list_b[$];
        logic signed [15:0]               list_w[$];
        int                               parent[MAX_V];
        int                               rank_of[MAX_V];
        int                               vcount = kmst_pkg::NV_RESET;
        bit                               dropped = 0;
        int                               errors = 0;

        function int root_of(int v);
            int r;
            int cur;
            int nxt;
            r = v;
            cur = v;
            while (parent[r] != r) r = parent[r];
            while (parent[cur] != r)
            begin
                nxt = parent[cur];
                parent[cur] = r;
                cur = nxt;
            end
            return r;
        endfunction

        function bit ahead(int i, int j);
            if (list_w[i] != list_w[j]) return list_w[i] < list_w[j];
            if (list_a[i] != list_a[j]) return list_a[i] < list_a[j];
            return list_b[i] < list_b[j];
        endfunction

        function void note_edge(logic [5:0] a, logic [5:0] b, logic signed [15:0] w,
                                bit eol);
            int lim;
            int j;
            int r1;
            int r2;
            int picked;
            logic [kmst_pkg::VERTEX_BITS-1:0] ta;
            logic [kmst_pkg::VERTEX_BITS-1:0] tb;
            logic signed [15:0] tw;
            logic [kmst_pkg::COST_BITS-1:0] sum;
            tree_beat_t t;
            lim = vcount > MAX_V ? MAX_V : vcount;
            if (a < lim && b < lim)
            begin
                if (list_a.size() < MAX_E)
                begin
                    list_a = {list_a, a};
                    list_b = {list_b, b};
                    list_w = {list_w, w};
                end
                else
                    dropped = 1;
            end
            if (!eol) return;
            for (int i = 1; i < list_a.size(); i++)
            begin
                j = i;
                while (j > 0 && ahead(j, j - 1))
                begin
                    ta = list_a[j]; list_a[j] = list_a[j-1]; list_a[j-1] = ta;
                    tb = list_b[j]; list_b[j] = list_b[j-1]; list_b[j-1] = tb;
                    tw = list_w[j]; list_w[j] = list_w[j-1]; list_w[j-1] = tw;
                    j--;
                end
            end
            for (int i = 0; i < MAX_V; i++)
            begin
                parent[i] = i;
                rank_of[i] = 1;
            end
            sum = '0;
            picked = 0;
            for (int i = 0; i < list_a.size(); i++)
            begin
                r1 = root_of(int'(list_a[i]));
                r2 = root_of(int'(list_b[i]));
                if (r1 != r2 && picked < MAX_V - 1)
                begin
                    if (rank_of[r1] < rank_of[r2])
                        parent[r1] = r2;
                    else if (rank_of[r1] > rank_of[r2])
                        parent[r2] = r1;
                    else
                    begin
                        parent[r2] = r1;
                        rank_of[r1] = (rank_of[r1] + 1) & 7;
                    end
                    sum = sum + {{(kmst_pkg::COST_BITS-16){list_w[i][15]}}, list_w[i]};
                    t = '{kmst_pkg::KIND_EDGE, list_a[i], list_b[i], list_w[i], sum,
                          dropped, 1'b0};
                    tree_q = {tree_q, t};
                    picked++;
                end
            end
            t = '{kmst_pkg::KIND_TOTAL, '0, '0, '0, sum, dropped, 1'b1};
            tree_q = {tree_q, t};
            list_a.delete();
            list_b.delete();
            list_w.delete();
            dropped = 0;
        endfunction

        function void check_beat(logic [55:0] d, logic user, logic lst);
            tree_beat_t e;
            if (tree_q.size() == 0)
            begin
                $error("unexpected output beat tdata=%h", d);
                errors++;
                return;
            end
            e = tree_q.pop_front();
            if (user !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, user); errors++;
            end
            if (d[5:0] !== e.a)
            begin
                $error("edge_a: expected %0d, got %0d", e.a, d[5:0]); errors++;
            end
            if (d[11:6] !== e.b)
            begin
                $error("edge_b: expected %0d, got %0d", e.b, d[11:6]); errors++;
            end
            if (d[27:12] !== e.w)
            begin
                $error("edge_weight: expected %h, got %h", e.w, d[27:12]); errors++;
            end
            if (d[49:28] !== e.cost)
            begin
                $error("total_cost: expected %h, got %h", e.cost, d[49:28]); errors++;
            end
            if (d[50] !== e.ovf)
            begin
                $error("overflow: expected %0d, got %0d", e.ovf, d[50]); errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, lst); errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [kmst_pkg::NV_BITS-1:0] cfg_wdata;

    mst_scoreboard sb;
    bit            gaps_on;
    int            hold_cycles;

    kruskal_minimum_spanning_tree_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_edge(input int a, input int b, input int w, input int eol);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, w[15:0], b[5:0], a[5:0]};
        s_tlast  <= eol[0];
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_edge(a[5:0], b[5:0], w[15:0], eol[0]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.tree_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vcount(input int v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[kmst_pkg::NV_BITS-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.vcount = v;
    endtask

    always
    begin
        int stall;
        if (rst_n !== 1'b1)
        begin
            m_tready <= 1'b0;
            @(posedge clk);
        end
        else
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
            begin
                stall = gaps_on ? $urandom_range(0, 4) : 0;
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid && hold_cycles == 0) @(posedge clk);
            if (m_tvalid)
                sb.check_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    initial
    begin
        int n;
        int nv;
        int lim;
        int a;
        int b;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        gaps_on = 1'b0;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_edge(0, 63, 'h8000, 0);
        send_edge(63, 0, 'h7fff, 0);
        send_edge(5, 5, 'h0000, 0);
        send_edge(1, 2, 'hffff, 0);
        send_edge(1, 2, 'hffff, 0);
        send_edge(2, 3, 100, 1);
        drain();
        write_vcount(1);
        send_edge(0, 0, 5, 0);
        send_edge(0, 1, 3, 1);
        drain();
        write_vcount(0);
        send_edge(0, 0, 1, 0);
        send_edge(0, 1, 7, 1);
        drain();
        write_vcount(127);
        send_edge(63, 62, 'h5555, 0);
        send_edge(62, 61, 'haaaa, 0);
        send_edge(63, 61, 'h0001, 1);
        drain();
        write_vcount(2);
        send_edge(0, 1, 9, 0);
        send_edge(1, 0, 9, 0);
        send_edge(2, 1, 1, 1);
        drain();

        // A longer list with scattered weights exercises the sort.
        write_vcount(64);
        gaps_on = 1'b1;
        for (int i = 0; i < 64; i++)
            send_edge(i % 64, (i * 7 + 1) % 64, (i * 97) % 211 - 100, int'(i == 63));
        drain();

        for (int run = 0; run < 22; run++)
        begin
            gaps_on = (run % 4) != 3;
            nv = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : 64;
            n = $urandom_range(1, 20);
            if (run == 5)
            begin
                nv = 64;
                n = 20;
                hold_cycles = 1500;
            end
            write_vcount(nv);
            lim = nv > 64 ? 64 : nv;
            for (int k = 0; k < n; k++)
            begin
                if (lim > 0 && $urandom_range(0, 9) != 0)
                begin
                    a = $urandom_range(0, lim - 1);
                    b = $urandom_range(0, lim - 1);
                end
                else
                begin
                    a = $urandom;
                    b = $urandom;
                end
                send_edge(a, b, $urandom, int'(k == n - 1));
            end
            if (run == 5)
            begin
                send_edge($urandom, $urandom, $urandom, 0);
                send_edge($urandom, $urandom, $urandom, 1);
            end
            drain();
        end

        if (sb.errors == 0 && sb.tree_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
